FILE: rtl/first_substring_match_core_assert.svh
// Assertion macros used by first_substring_match_core.
`ifndef FIRST_SUBSTRING_MATCH_CORE_ASSERT_SVH
`define FIRST_SUBSTRING_MATCH_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define FSM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("first_substring_match_core: check failed");

// Next-cycle implication, checked outside reset.
`define FSM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("first_substring_match_core: check failed");

`endif

FILE: rtl/fsm_pkg.sv
package fsm_pkg;

  // Default sizes
  localparam int              PATTERN_MAX_DEF = 16;
  localparam longint unsigned TEXT_MAX_DEF    = 64'd65536;

  // Field widths
  localparam int CMD_W    = 2;
  localparam int BYTE_W   = 8;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 16;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_PATTERN = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TEXT    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FINISH  = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_FOUND     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_PAT_LONG  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_TEXT_LONG = 2'd3;
  localparam logic [STATUS_W-1:0] ST_NONE      = 2'd0;

  // Control broadcast to every cell of the chain
  typedef struct packed {
    logic shift_pat;
    logic shift_txt;
    logic clear;
  } cell_ctrl_t;

endpackage

FILE: rtl/fsm_cell.sv
module fsm_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  fsm_pkg::cell_ctrl_t       ctrl,
  input  logic [fsm_pkg::BYTE_W-1:0] pat_in,
  input  logic                      pval_in,
  input  logic [fsm_pkg::BYTE_W-1:0] txt_in,
  output logic [fsm_pkg::BYTE_W-1:0] pat_out,
  output logic                      pval_out,
  output logic [fsm_pkg::BYTE_W-1:0] txt_out,
  output logic                      hit
);
  import fsm_pkg::*;

  logic [BYTE_W-1:0] pat;
  logic              pval;
  logic [BYTE_W-1:0] txt;

  // Hold one pattern byte and its valid flag; shift on pattern items
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      pval <= 1'b0;
    end else if (ctrl.shift_pat) begin
      pval <= pval_in;
    end
    if (ctrl.shift_pat) begin
      pat <= pat_in;
    end
  end

  // Hold one window byte; advance on text items
  always_ff @(posedge clk) begin
    if (ctrl.shift_txt) begin
      txt <= txt_in;
    end
  end

  // Compare the byte that enters this cell with the stored pattern byte
  assign hit      = !pval || (txt_in == pat);
  assign pat_out  = pat;
  assign pval_out = pval;
  assign txt_out  = txt;

endmodule

FILE: rtl/first_substring_match_core.sv
// first_substring_match_core: finds the first offset of a pattern in a byte stream.
// Input channel (in_valid/in_ready): command with data_byte. Pattern items
// load the pattern, text items stream the text, a finish item reports.
// Output channel (out_valid/out_ready): one item per finish, carrying status
// (found, not found, pattern too long, text too long) and position.
// The block accepts one item per clock unless a result waits unread.
// This rate rests on the chain of cells: each cell holds one pattern byte
// and one window byte, and all cells compare the shifted window in parallel
// with the pattern, so a text byte is checked in the cycle it is accepted.
// A finish result appears on the output register in the cycle after the
// finish item is accepted. While that result waits, the block still accepts
// items as long as the output register is free or being drained in the
// same cycle; a stalled receiver holds in_ready low only while a result
// sits unread. Reset (rst, synchronous) empties the pattern and text,
// clears the match record and any overflow flag, and drops any result.
// A finish also returns the block to that empty state.
module first_substring_match_core #(
  parameter int              PATTERN_MAX = fsm_pkg::PATTERN_MAX_DEF,
  parameter longint unsigned TEXT_MAX    = fsm_pkg::TEXT_MAX_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [fsm_pkg::CMD_W-1:0]    command,
  input  logic [fsm_pkg::BYTE_W-1:0]   data_byte,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [fsm_pkg::STATUS_W-1:0] status,
  output logic [fsm_pkg::POS_W-1:0]    position
);
  import fsm_pkg::*;

  localparam int PC_W  = $clog2(PATTERN_MAX + 1);
  localparam int TC_W  = $clog2(TEXT_MAX + 64'd1);
  localparam int CMP_W = (PC_W > TC_W) ? PC_W : TC_W;

  logic [PC_W-1:0]     pattern_count;
  logic [TC_W-1:0]     text_count;
  logic                match_seen;
  logic [POS_W-1:0]    match_offset;
  logic [STATUS_W-1:0] overflow_code;

  cell_ctrl_t          ctrl;
  logic                accept;
  logic                is_pat, is_txt, is_fin;
  logic                pat_full, txt_full;
  logic [CMP_W-1:0]    count_next_ext;
  logic [CMP_W-1:0]    pc_ext;
  logic                full_match;

  logic [BYTE_W-1:0]      pat_chain  [PATTERN_MAX+1];
  logic                   pval_chain [PATTERN_MAX+1];
  logic [BYTE_W-1:0]      txt_chain  [PATTERN_MAX+1];
  logic [PATTERN_MAX-1:0] hits;

  // Decode the accepted item
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign is_pat   = (command == CMD_PATTERN);
  assign is_txt   = (command == CMD_TEXT);
  assign is_fin   = (command == CMD_FINISH);
  assign pat_full = (pattern_count >= PC_W'(PATTERN_MAX));
  assign txt_full = (text_count >= TC_W'(TEXT_MAX));

  assign ctrl.shift_pat = accept && is_pat && (text_count == '0) && !pat_full;
  assign ctrl.shift_txt = accept && is_txt && !txt_full;
  assign ctrl.clear     = accept && is_fin;

  // Feed the head of the chain
  assign pat_chain[0]  = data_byte;
  assign pval_chain[0] = 1'b1;
  assign txt_chain[0]  = data_byte;

  // Build the row of cells
  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
    fsm_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .pat_in   (pat_chain[k]),
      .pval_in  (pval_chain[k]),
      .txt_in   (txt_chain[k]),
      .pat_out  (pat_chain[k+1]),
      .pval_out (pval_chain[k+1]),
      .txt_out  (txt_chain[k+1]),
      .hit      (hits[k])
    );
  end

  // Check the window that the current text byte completes
  assign count_next_ext = CMP_W'(text_count) + CMP_W'(1);
  assign pc_ext         = CMP_W'(pattern_count);
  assign full_match     = !match_seen && (pattern_count != '0) &&
                          (count_next_ext >= pc_ext) && (&hits);

  // Advance counters, record the first match, flag overflow
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      pattern_count <= '0;
      text_count    <= '0;
      match_seen    <= 1'b0;
      match_offset  <= '0;
      overflow_code <= ST_NONE;
    end else if (accept) begin
      if (ctrl.shift_pat) begin
        pattern_count <= pattern_count + PC_W'(1);
      end
      if (is_pat && (text_count == '0) && pat_full && (overflow_code == ST_NONE)) begin
        overflow_code <= ST_PAT_LONG;
      end
      if (ctrl.shift_txt) begin
        text_count <= text_count + TC_W'(1);
        if (full_match) begin
          match_seen   <= 1'b1;
          match_offset <= POS_W'(count_next_ext - pc_ext);
        end
      end
      if (is_txt && txt_full && (overflow_code == ST_NONE)) begin
        overflow_code <= ST_TEXT_LONG;
      end
    end
  end

  // Hold the result until the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.clear) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (ctrl.clear) begin
      if (overflow_code != ST_NONE) begin
        status   <= overflow_code;
        position <= '0;
      end else if (pattern_count == '0) begin
        status   <= ST_FOUND;
        position <= '0;
      end else if (match_seen) begin
        status   <= ST_FOUND;
        position <= match_offset;
      end else begin
        status   <= ST_NOT_FOUND;
        position <= '0;
      end
    end
  end

`include "first_substring_match_core_assert.svh"

  `FSM_ASSERT_NEXT(a_finish_clears, ctrl.clear, (pattern_count == '0) && (text_count == '0) && !match_seen)
  `FSM_ASSERT_NOW(a_match_needs_pattern, match_seen, pattern_count != '0)
  `FSM_ASSERT_NOW(a_head_valid_tracks_count, 1'b1, pval_chain[1] == (pattern_count != '0))
  `FSM_ASSERT_NEXT(a_pattern_locked, accept && is_pat && (text_count != '0), $stable(pattern_count))

endmodule

FILE: test/first_substring_match_core_tb.sv
`timescale 1ns / 1ps

module first_substring_match_core_tb;
  import fsm_pkg::*;

  localparam int              PAT_DEPTH   = PATTERN_MAX_DEF;
  localparam longint unsigned TEXT_LIMIT  = TEXT_MAX_DEF;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int              N_DIRECTED  = 24;
  localparam int              RAND_ITEMS  = 340;
  localparam int              DRAIN_LIMIT = 1000;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    position;
  } search_result_t;

  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [BYTE_W-1:0]   data;
    logic [16:0]         reps;
    logic                typed;
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    position;
  } stim_row_t;

  logic                clk;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [CMD_W-1:0]    command = CMD_PATTERN;
  logic [BYTE_W-1:0]   data_byte = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [POS_W-1:0]    position;

  // Search state mirrored from the block
  logic [BYTE_W-1:0]   pat_bytes [PAT_DEPTH];
  logic [4:0]          pat_len;
  logic [BYTE_W-1:0]   win_bytes [PAT_DEPTH];
  logic [16:0]         text_len;
  logic                hit_seen;
  logic [POS_W-1:0]    hit_offset;
  logic [STATUS_W-1:0] ovf_code;

  search_result_t pending_results [$];

  int snd_idle_pct = 24;
  int rcv_idle_pct = 83;
  int items_sent;
  int searches_checked;
  int found_count;
  int missed_count;
  int overflow_count;
  int mismatches;

  // Directed stimulus: typed results only where obvious
  stim_row_t directed_rows [N_DIRECTED] = '{
    '{CMD_FINISH,  8'hFF, 17'd1,     1'b1, ST_FOUND,     16'd0},
    '{CMD_TEXT,    8'h12, 17'd1,     1'b0, ST_NONE,      16'd0},
    '{CMD_FINISH,  8'h00, 17'd1,     1'b1, ST_FOUND,     16'd0},
    '{CMD_PATTERN, 8'hAB, 17'd1,     1'b0, ST_NONE,      16'd0},
    '{CMD_UNUSED,  8'h55, 17'd1,     1'b0, ST_NONE,      16'd0},
    '{CMD_FINISH,  8'h00, 17'd1,     1'b1, ST_NOT_FOUND, 16'd0},
    '{CMD_PATTERN, 8'h00, 17'd1,     1'b0, ST_NONE,      16'd0},
    '{CMD_PATTERN, 8'hFF, 17'd1,     1'b0, ST_NONE,      16'd0},
    '{CMD_TEXT,    8'h00, 17'd1,     1'b0, ST_NONE,      16'd0},
    '{CMD_TEXT,    8'hFF, 17'd1,     1'b0, ST_NONE,      16'd0},
    '{CMD_PATTERN, 8'h11, 17'd1,     1'b0, ST_NONE,      16'd0},
    '{CMD_TEXT,    8'h00, 17'd1,     1'b0, ST_NONE,      16'd0},
    '{CMD_FINISH,  8'h00, 17'd1,     1'b0, ST_NONE,      16'd0},
    '{CMD_PATTERN, 8'h5A, 17'd17,    1'b0, ST_NONE,      16'd0},
    '{CMD_FINISH,  8'h00, 17'd1,     1'b1, ST_PAT_LONG,  16'd0},
    '{CMD_PATTERN, 8'hA5, 17'd1,     1'b0, ST_NONE,      16'd0},
    '{CMD_TEXT,    8'h00, 17'd3,     1'b0, ST_NONE,      16'd0},
    '{CMD_TEXT,    8'hA5, 17'd1,     1'b0, ST_NONE,      16'd0},
    '{CMD_FINISH,  8'h00, 17'd1,     1'b1, ST_FOUND,     16'd3},
    '{CMD_TEXT,    8'h3C, 17'd5,     1'b0, ST_NONE,      16'd0},
    '{CMD_FINISH,  8'h00, 17'd1,     1'b1, ST_FOUND,     16'd0},
    '{CMD_PATTERN, 8'h77, 17'd17,    1'b0, ST_NONE,      16'd0},
    '{CMD_TEXT,    8'h77, 17'd5,     1'b0, ST_NONE,      16'd0},
    '{CMD_FINISH,  8'h00, 17'd1,     1'b1, ST_PAT_LONG,  16'd0}
  };

  first_substring_match_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .command   (command),
    .data_byte (data_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .position  (position)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Return the search state to empty
  task automatic clear_search();
    for (int i = 0; i < PAT_DEPTH; i++) begin
      pat_bytes[i] = '0;
      win_bytes[i] = '0;
    end
    pat_len    = '0;
    text_len   = '0;
    hit_seen   = 1'b0;
    hit_offset = '0;
    ovf_code   = ST_NONE;
  endtask

  // Advance the search state by one item; report a result on finish
  task automatic search_step(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] b,
                             output bit has_result, output search_result_t res);
    bit          window_ok;
    logic [16:0] start;
    has_result = 1'b0;
    res        = '0;
    case (cmd)
      CMD_PATTERN: begin
        // pattern locks once text has begun
        if (text_len == 0) begin
          if (pat_len >= PAT_DEPTH) begin
            if (ovf_code == ST_NONE) ovf_code = ST_PAT_LONG;
          end else begin
            pat_bytes[pat_len[3:0]] = b;
            pat_len = pat_len + 5'd1;
          end
        end
      end
      CMD_TEXT: begin
        if (text_len >= TEXT_LIMIT) begin
          if (ovf_code == ST_NONE) ovf_code = ST_TEXT_LONG;
        end else begin
          for (int k = PAT_DEPTH - 1; k > 0; k--) win_bytes[k] = win_bytes[k-1];
          win_bytes[0] = b;
          text_len = text_len + 17'd1;
          if (!hit_seen && pat_len != 0 && text_len >= pat_len) begin
            window_ok = 1'b1;
            for (int j = 0; j < pat_len; j++)
              if (win_bytes[pat_len - 1 - j] != pat_bytes[j]) window_ok = 1'b0;
            if (window_ok) begin
              start      = text_len - pat_len;
              hit_seen   = 1'b1;
              hit_offset = start[POS_W-1:0];
            end
          end
        end
      end
      CMD_FINISH: begin
        has_result = 1'b1;
        if (ovf_code != ST_NONE) res.status = ovf_code;
        else if (pat_len == 0) res.status = ST_FOUND;
        else if (hit_seen) begin
          res.status   = ST_FOUND;
          res.position = hit_offset;
        end else res.status = ST_NOT_FOUND;
        clear_search();
      end
      default: ;
    endcase
  endtask

  // Offer one item, hold it until taken, then record what it should produce
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] b,
                           input bit use_typed, input search_result_t typed_res);
    bit             has_result;
    search_result_t res;
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    command   <= cmd;
    data_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    search_step(cmd, b, has_result, res);
    if (has_result) pending_results.push_back(use_typed ? typed_res : res);
    if (cmd != CMD_UNUSED) items_sent++;
    @(negedge clk);
  endtask

  // Hold the sender until every outstanding result is out
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // Occasionally slip in an ignored command or a stray pattern byte
  task automatic add_noise();
    int r;
    r = $urandom_range(99);
    if (r < 4) send_item(CMD_UNUSED, 8'($urandom_range(255)), 1'b0, '0);
    else if (r < 6) send_item(CMD_PATTERN, 8'($urandom_range(255)), 1'b0, '0);
  endtask

  // One search: pattern, text with the pattern sometimes planted, then finish
  task automatic run_search_sequence();
    logic [BYTE_W-1:0] pat [20];
    logic [BYTE_W-1:0] txt [24];
    logic [BYTE_W-1:0] a0;
    logic [BYTE_W-1:0] a1;
    bit                wide;
    int                plen;
    int                tlen;
    int                where;
    int                r;
    r = $urandom_range(99);
    if (r < 6) plen = 0;
    else if (r < 14) plen = $urandom_range(19, 17);
    else if (r < 22) plen = PAT_DEPTH;
    else plen = $urandom_range(5, 1);
    wide = ($urandom_range(99) < 25);
    a0   = 8'($urandom_range(255));
    a1   = 8'($urandom_range(255));
    for (int i = 0; i < 20; i++) begin
      if (wide) pat[i] = 8'($urandom_range(255));
      else pat[i] = $urandom_range(1) ? a0 : a1;
    end
    tlen = $urandom_range(24, 0);
    for (int i = 0; i < 24; i++) begin
      if (wide) txt[i] = 8'($urandom_range(255));
      else txt[i] = $urandom_range(1) ? a0 : a1;
    end
    if (plen > 0 && plen <= tlen && $urandom_range(99) < 40) begin
      where = $urandom_range(tlen - plen, 0);
      for (int j = 0; j < plen; j++) txt[where + j] = pat[j];
    end
    for (int i = 0; i < plen; i++) begin
      add_noise();
      send_item(CMD_PATTERN, pat[i], 1'b0, '0);
    end
    for (int i = 0; i < tlen; i++) begin
      add_noise();
      send_item(CMD_TEXT, txt[i], 1'b0, '0);
    end
    // a few searches run on without a finish
    if ($urandom_range(99) < 92) send_item(CMD_FINISH, 8'($urandom_range(255)), 1'b0, '0);
  endtask

  // Receiver stalls
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  // Compare each result with the oldest expectation
  always @(posedge clk) begin
    search_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: status %0d position %0d", status, position);
      end else begin
        want = pending_results.pop_front();
        searches_checked++;
        if (want.status == ST_FOUND) found_count++;
        else if (want.status == ST_NOT_FOUND) missed_count++;
        else overflow_count++;
        if (status !== want.status || position !== want.position) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d: expected status %0d position %0d, got %0d %0d",
                     searches_checked, want.status, want.position, status, position);
        end
      end
    end
  end

  initial begin
    int phase;
    int next_phase;
    int drain;
    clear_search();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed part
    foreach (directed_rows[r]) begin
      for (int n = 0; n < directed_rows[r].reps; n++)
        send_item(directed_rows[r].cmd, directed_rows[r].data, directed_rows[r].typed,
                  {directed_rows[r].status, directed_rows[r].position});
    end
    wait_results_drained();

    // random part, idling swapped then off
    items_sent = 0;
    phase = 0;
    while (items_sent < RAND_ITEMS) begin
      run_search_sequence();
      next_phase = (items_sent < RAND_ITEMS / 3) ? 0 : (items_sent < 2 * RAND_ITEMS / 3) ? 1 : 2;
      if (next_phase != phase || $urandom_range(99) < 8) wait_results_drained();
      if (next_phase != phase) begin
        phase        = next_phase;
        snd_idle_pct = (phase == 1) ? 83 : 0;
        rcv_idle_pct = (phase == 1) ? 24 : 0;
      end
    end

    // drain
    in_valid <= 1'b0;
    drain = 0;
    while (pending_results.size() != 0 && drain < DRAIN_LIMIT) begin
      @(negedge clk);
      drain++;
    end
    repeat (20) @(negedge clk);
    if (pending_results.size() != 0) begin
      $display("%0d expected results never arrived", pending_results.size());
      mismatches += pending_results.size();
    end

    $display("Checked %0d searches: %0d found, %0d not found, %0d overflow",
             searches_checked, found_count, missed_count, overflow_count);
    $display("Random part sent %0d items after the directed table", items_sent);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
